### design/lsi_pkg.sv
// Shared widths, codes and types for the line segment intersection block.
package lsi_pkg;

    localparam int LSI_FRAC_BITS = 16;

    localparam int COORD_W = 32;
    localparam int LIMIT_W = 31;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd6554;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DEN_W  = PROD_W + 1;
    localparam int DABS_W = PROD_W;
    localparam int LO_W   = DIFF_W + 1;
    localparam int TRIP_W = 99;
    localparam int NUM_W  = 100;
    localparam int Q_W    = 34;
    localparam int MAG_W  = Q_W + 1;
    localparam int VAL_W  = Q_W + 2;

    localparam logic [1:0] ST_CROSS    = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
    } pts_t;

    typedef struct packed {
        pts_t pts;
        logic must;
        logic par;
        logic neg_x;
        logic neg_y;
    } side_t;

endpackage

### design/lsi_front.sv
// Front pipeline: differences, cross products, numerators, denominator and parallel test.
module lsi_front
    import lsi_pkg::*;
#(
    parameter int FRAC_BITS = LSI_FRAC_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [LIMIT_W-1:0]  limit,
    input  logic                in_valid,
    output logic                in_ready,
    input  pts_t                in_pts,
    input  logic                in_must,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [NUM_W-1:0]    out_num_x,
    output logic [NUM_W-1:0]    out_num_y,
    output logic [DABS_W-1:0]   out_den,
    output side_t               out_side
);

    localparam int NS = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN = LIMIT_W'(((1 << FRAC_BITS) + 5) / 10);

    logic v_reg [NS];
    logic rdy [NS+1];
    pts_t pts_reg [NS];
    logic must_reg [NS];

    logic signed [DIFF_W-1:0] abx_reg, aby_reg, cdx_reg, cdy_reg, cyay_reg, cxax_reg;
    logic signed [DIFF_W-1:0] cyay1_reg, cxax1_reg;
    logic signed [PROD_W-1:0] p_reg [4];
    logic signed [DEN_W-1:0]  den2_reg;
    logic signed [LO_W+DIFF_W-2:0] lo_reg [6];
    logic signed [PROD_W-1:0] hi_reg [6];
    logic signed [TRIP_W-1:0] t_reg [6];
    logic [DABS_W-1:0] den3_reg, den4_reg, den5_reg;
    logic den_neg3_reg, den_neg4_reg;
    logic signed [NUM_W-1:0] nx4_reg, ny4_reg;
    logic par4_reg;
    logic [NUM_W-1:0] nx5_reg, ny5_reg;
    logic par5_reg, neg_x5_reg, neg_y5_reg;

    logic signed [PROD_W-1:0] tp [6];
    logic signed [DIFF_W-1:0] tf [6];
    logic signed [LO_W+DIFF_W-2:0] lo_next [6];
    logic signed [PROD_W-1:0] hi_next [6];
    logic signed [TRIP_W-1:0] t_next [6];
    logic [LIMIT_W-1:0] lim;
    logic [DABS_W-1:0] thr;

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Triple products split into a low unsigned and a high signed half of the first factor.
    always_comb
    begin
        tp[0] = p_reg[0]; tf[0] = cyay1_reg;
        tp[1] = p_reg[1]; tf[1] = DIFF_W'(pts_reg[1].ax);
        tp[2] = p_reg[2]; tf[2] = DIFF_W'(pts_reg[1].cx);
        tp[3] = p_reg[1]; tf[3] = DIFF_W'(pts_reg[1].cy);
        tp[4] = p_reg[3]; tf[4] = cxax1_reg;
        tp[5] = p_reg[2]; tf[5] = DIFF_W'(pts_reg[1].ay);
        for (int i = 0; i < 6; i++)
        begin
            lo_next[i] = $signed({1'b0, tp[i][DIFF_W-1:0]}) * tf[i];
            hi_next[i] = $signed(tp[i][PROD_W-1:DIFF_W]) * tf[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            t_next[i] = $signed({hi_reg[i], {DIFF_W{1'b0}}}) + TRIP_W'(lo_reg[i]);
        end
        lim = (limit < LIMIT_MIN) ? LIMIT_MIN : limit;
        thr = DABS_W'(lim) << FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pts_reg[0]  <= in_pts;
            must_reg[0] <= in_must;
            abx_reg  <= DIFF_W'(in_pts.bx) - DIFF_W'(in_pts.ax);
            aby_reg  <= DIFF_W'(in_pts.by) - DIFF_W'(in_pts.ay);
            cdx_reg  <= DIFF_W'(in_pts.dx) - DIFF_W'(in_pts.cx);
            cdy_reg  <= DIFF_W'(in_pts.dy) - DIFF_W'(in_pts.cy);
            cyay_reg <= DIFF_W'(in_pts.cy) - DIFF_W'(in_pts.ay);
            cxax_reg <= DIFF_W'(in_pts.cx) - DIFF_W'(in_pts.ax);
        end
        if (rdy[1])
        begin
            pts_reg[1]  <= pts_reg[0];
            must_reg[1] <= must_reg[0];
            p_reg[0]  <= abx_reg * cdx_reg;
            p_reg[1]  <= aby_reg * cdx_reg;
            p_reg[2]  <= abx_reg * cdy_reg;
            p_reg[3]  <= aby_reg * cdy_reg;
            cyay1_reg <= cyay_reg;
            cxax1_reg <= cxax_reg;
        end
        if (rdy[2])
        begin
            pts_reg[2]  <= pts_reg[1];
            must_reg[2] <= must_reg[1];
            den2_reg <= DEN_W'(p_reg[1]) - DEN_W'(p_reg[2]);
            for (int i = 0; i < 6; i++)
            begin
                lo_reg[i] <= lo_next[i];
                hi_reg[i] <= hi_next[i];
            end
        end
        if (rdy[3])
        begin
            pts_reg[3]  <= pts_reg[2];
            must_reg[3] <= must_reg[2];
            for (int i = 0; i < 6; i++)
            begin
                t_reg[i] <= t_next[i];
            end
            den3_reg     <= den2_reg[DEN_W-1] ? DABS_W'(-den2_reg) : den2_reg[DABS_W-1:0];
            den_neg3_reg <= den2_reg[DEN_W-1];
        end
        if (rdy[4])
        begin
            pts_reg[4]  <= pts_reg[3];
            must_reg[4] <= must_reg[3];
            nx4_reg <= NUM_W'(t_reg[0]) + NUM_W'(t_reg[1]) - NUM_W'(t_reg[2]);
            ny4_reg <= NUM_W'(t_reg[3]) - NUM_W'(t_reg[4]) - NUM_W'(t_reg[5]);
            den4_reg     <= den3_reg;
            den_neg4_reg <= den_neg3_reg;
            par4_reg     <= (den3_reg <= thr);
        end
        if (rdy[5])
        begin
            pts_reg[5]  <= pts_reg[4];
            must_reg[5] <= must_reg[4];
            nx5_reg    <= nx4_reg[NUM_W-1] ? NUM_W'(-nx4_reg) : NUM_W'(nx4_reg);
            ny5_reg    <= ny4_reg[NUM_W-1] ? NUM_W'(-ny4_reg) : NUM_W'(ny4_reg);
            neg_x5_reg <= nx4_reg[NUM_W-1] ^ den_neg4_reg;
            neg_y5_reg <= ny4_reg[NUM_W-1] ^ den_neg4_reg;
            den5_reg   <= den4_reg;
            par5_reg   <= par4_reg;
        end
    end

    assign out_valid      = v_reg[NS-1];
    assign out_num_x      = nx5_reg;
    assign out_num_y      = ny5_reg;
    assign out_den        = den5_reg;
    assign out_side.pts   = pts_reg[NS-1];
    assign out_side.must  = must_reg[NS-1];
    assign out_side.par   = par5_reg;
    assign out_side.neg_x = neg_x5_reg;
    assign out_side.neg_y = neg_y5_reg;

endmodule

### design/lsi_div.sv
// Pipelined restoring divider, one quotient bit per stage after the first, two lanes sharing one divisor.
module lsi_div
    import lsi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [NUM_W-1:0]   in_num_x,
    input  logic [NUM_W-1:0]   in_num_y,
    input  logic [DABS_W-1:0]  in_den,
    input  side_t              in_side,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [Q_W-1:0]     out_q_x,
    output logic [Q_W-1:0]     out_q_y,
    output logic [NUM_W-1:0]   out_r_x,
    output logic [NUM_W-1:0]   out_r_y,
    output logic               out_ovf_x,
    output logic               out_ovf_y,
    output logic [DABS_W-1:0]  out_den,
    output side_t              out_side
);

    localparam int NS = Q_W + 1;

    logic v_reg [NS];
    logic rdy [NS+1];
    logic [NUM_W-1:0] rx_reg [NS];
    logic [NUM_W-1:0] ry_reg [NS];
    logic [Q_W-1:0] qx_reg [NS];
    logic [Q_W-1:0] qy_reg [NS];
    logic ovfx_reg [NS];
    logic ovfy_reg [NS];
    logic [DABS_W-1:0] den_reg [NS];
    side_t side_reg [NS];

    logic [NUM_W-1:0] top_cmp;

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // A quotient that needs more than Q_W bits is flagged and saturated later.
    assign top_cmp = NUM_W'(in_den) << Q_W;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            rx_reg[0]   <= in_num_x;
            ry_reg[0]   <= in_num_y;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            ovfx_reg[0] <= (in_num_x >= top_cmp);
            ovfy_reg[0] <= (in_num_y >= top_cmp);
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 1; j < NS; j++)
    begin : g_bit
        localparam int K = Q_W - j;
        logic [NUM_W-1:0] cmp;

        assign cmp = NUM_W'(den_reg[j-1]) << K;

        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                den_reg[j]  <= den_reg[j-1];
                side_reg[j] <= side_reg[j-1];
                ovfx_reg[j] <= ovfx_reg[j-1];
                ovfy_reg[j] <= ovfy_reg[j-1];
                if (rx_reg[j-1] >= cmp)
                begin
                    rx_reg[j] <= rx_reg[j-1] - cmp;
                    qx_reg[j] <= qx_reg[j-1] | (Q_W'(1) << K);
                end
                else
                begin
                    rx_reg[j] <= rx_reg[j-1];
                    qx_reg[j] <= qx_reg[j-1];
                end
                if (ry_reg[j-1] >= cmp)
                begin
                    ry_reg[j] <= ry_reg[j-1] - cmp;
                    qy_reg[j] <= qy_reg[j-1] | (Q_W'(1) << K);
                end
                else
                begin
                    ry_reg[j] <= ry_reg[j-1];
                    qy_reg[j] <= qy_reg[j-1];
                end
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_q_x   = qx_reg[NS-1];
    assign out_q_y   = qy_reg[NS-1];
    assign out_r_x   = rx_reg[NS-1];
    assign out_r_y   = ry_reg[NS-1];
    assign out_ovf_x = ovfx_reg[NS-1];
    assign out_ovf_y = ovfy_reg[NS-1];
    assign out_den   = den_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

### design/lsi_back.sv
// Back pipeline: rounding, sign, segment test, saturation and the output register.
module lsi_back
    import lsi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [Q_W-1:0]     in_q_x,
    input  logic [Q_W-1:0]     in_q_y,
    input  logic [NUM_W-1:0]   in_r_x,
    input  logic [NUM_W-1:0]   in_r_y,
    input  logic               in_ovf_x,
    input  logic               in_ovf_y,
    input  logic [DABS_W-1:0]  in_den,
    input  side_t              in_side,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y
);

    localparam int NS = 3;
    localparam logic [MAG_W-1:0] MAG_SAT = MAG_W'(1) << Q_W;

    logic v_reg [NS];
    logic rdy [NS+1];
    side_t side0_reg, side1_reg;
    logic [MAG_W-1:0] mx_reg, my_reg;
    logic signed [VAL_W-1:0] vx_reg, vy_reg;
    logic [1:0] status_reg;
    logic [COORD_W-1:0] x_reg, y_reg;

    logic rnd_x, rnd_y;
    logic on_seg;

    function automatic logic between(input logic signed [VAL_W-1:0] v,
                                     input logic signed [COORD_W-1:0] p,
                                     input logic signed [COORD_W-1:0] q);
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        lo = (p < q) ? VAL_W'(p) : VAL_W'(q);
        hi = (p < q) ? VAL_W'(q) : VAL_W'(p);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic [COORD_W-1:0] sat(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] vmax;
        logic signed [VAL_W-1:0] vmin;
        vmax = VAL_W'({1'b0, {(COORD_W-1){1'b1}}});
        vmin = -vmax - VAL_W'(1);
        if (v > vmax)
        begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (v < vmin)
        begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return v[COORD_W-1:0];
    endfunction

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Round half away from zero on the magnitude: bump when twice the remainder reaches the divisor.
    assign rnd_x = ((NUM_W + 1)'(in_r_x) << 1) >= (NUM_W + 1)'(in_den);
    assign rnd_y = ((NUM_W + 1)'(in_r_y) << 1) >= (NUM_W + 1)'(in_den);

    assign on_seg = between(vx_reg, side1_reg.pts.ax, side1_reg.pts.bx)
                 && between(vy_reg, side1_reg.pts.ay, side1_reg.pts.by)
                 && between(vx_reg, side1_reg.pts.cx, side1_reg.pts.dx)
                 && between(vy_reg, side1_reg.pts.cy, side1_reg.pts.dy);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            side0_reg <= in_side;
            mx_reg <= in_ovf_x ? MAG_SAT : MAG_W'(in_q_x) + MAG_W'(rnd_x);
            my_reg <= in_ovf_y ? MAG_SAT : MAG_W'(in_q_y) + MAG_W'(rnd_y);
        end
        if (rdy[1])
        begin
            side1_reg <= side0_reg;
            vx_reg <= side0_reg.neg_x ? -$signed({1'b0, mx_reg}) : $signed({1'b0, mx_reg});
            vy_reg <= side0_reg.neg_y ? -$signed({1'b0, my_reg}) : $signed({1'b0, my_reg});
        end
        if (rdy[2])
        begin
            if (side1_reg.par)
            begin
                status_reg <= ST_PARALLEL;
                x_reg <= '0;
                y_reg <= '0;
            end
            else if (side1_reg.must && !on_seg)
            begin
                status_reg <= ST_OUTSIDE;
                x_reg <= '0;
                y_reg <= '0;
            end
            else
            begin
                status_reg <= ST_CROSS;
                x_reg <= sat(vx_reg);
                y_reg <= sat(vy_reg);
            end
        end
    end

    assign out_valid  = v_reg[NS-1];
    assign out_status = status_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;

endmodule

### design/line_segment_intersection_top.sv
// Top level of the two-dimensional line and segment intersection pipeline.
//
//  Channel   Direction  Handshake                     Payload
//  cfg       in         cfg_valid / cfg_ready         cfg_data: parallel_limit (31 bits)
//  s_axis    in         s_axis_tvalid / tready        tdata: a_x..d_y, tuser: must_lie_on_segments
//  m_axis    out        m_axis_tvalid / tready        tdata: cross_x, cross_y, tuser: status
//
// One transfer per cycle is accepted in steady state while the output is not stalled; each item
// passes 6 front stages, 35 divider stages and 3 back stages. The first divider stage checks for
// overflow, and each later one forms one quotient bit for both crossing coordinates.
// Reset clears only the valid bits of every stage and loads the limit register with its default.
// A stall on the output holds only the stages that are full; bubbles ahead of it still close up,
// so new transfers are taken until every stage holds an item. Nothing is lost or repeated.
module line_segment_intersection_top
    import lsi_pkg::*;
#(
    parameter int FRAC_BITS = LSI_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LIMIT_W-1:0]   cfg_data,       // parallel_limit
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [8*COORD_W-1:0] s_axis_tdata,   // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
    input  logic [0:0]           s_axis_tuser,   // must_lie_on_segments
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*COORD_W-1:0] m_axis_tdata,   // cross_x, cross_y
    output logic [1:0]           m_axis_tuser    // status
);

    logic [LIMIT_W-1:0] limit_reg;
    pts_t in_pts;

    logic               f_valid, f_ready;
    logic [NUM_W-1:0]   f_num_x, f_num_y;
    logic [DABS_W-1:0]  f_den;
    side_t              f_side;

    logic               d_valid, d_ready;
    logic [Q_W-1:0]     d_q_x, d_q_y;
    logic [NUM_W-1:0]   d_r_x, d_r_y;
    logic               d_ovf_x, d_ovf_y;
    logic [DABS_W-1:0]  d_den;
    side_t              d_side;

    logic [1:0]         b_status;
    logic [COORD_W-1:0] b_x, b_y;

    // Limit writes go in unchecked; user writes must arrive only while the pipeline is empty.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    assign in_pts.ax = s_axis_tdata[0*COORD_W +: COORD_W];
    assign in_pts.ay = s_axis_tdata[1*COORD_W +: COORD_W];
    assign in_pts.bx = s_axis_tdata[2*COORD_W +: COORD_W];
    assign in_pts.by = s_axis_tdata[3*COORD_W +: COORD_W];
    assign in_pts.cx = s_axis_tdata[4*COORD_W +: COORD_W];
    assign in_pts.cy = s_axis_tdata[5*COORD_W +: COORD_W];
    assign in_pts.dx = s_axis_tdata[6*COORD_W +: COORD_W];
    assign in_pts.dy = s_axis_tdata[7*COORD_W +: COORD_W];

    // Products, numerators, denominator magnitude and the near-parallel decision.
    lsi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pts    (in_pts),
        .in_must   (s_axis_tuser[0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_num_x (f_num_x),
        .out_num_y (f_num_y),
        .out_den   (f_den),
        .out_side  (f_side)
    );

    // Magnitude division of both numerators by the shared denominator.
    lsi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_num_x  (f_num_x),
        .in_num_y  (f_num_y),
        .in_den    (f_den),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_q_x   (d_q_x),
        .out_q_y   (d_q_y),
        .out_r_x   (d_r_x),
        .out_r_y   (d_r_y),
        .out_ovf_x (d_ovf_x),
        .out_ovf_y (d_ovf_y),
        .out_den   (d_den),
        .out_side  (d_side)
    );

    // Rounding, sign, segment bounds, saturation; its last stage is the output register.
    lsi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d_valid),
        .in_ready   (d_ready),
        .in_q_x     (d_q_x),
        .in_q_y     (d_q_y),
        .in_r_x     (d_r_x),
        .in_r_y     (d_r_y),
        .in_ovf_x   (d_ovf_x),
        .in_ovf_y   (d_ovf_y),
        .in_den     (d_den),
        .in_side    (d_side),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (b_status),
        .out_x      (b_x),
        .out_y      (b_y)
    );

    assign m_axis_tdata = {b_y, b_x};
    assign m_axis_tuser = b_status;

`ifndef NO_ASSERTIONS
    // The input side may only back up when the output holds an untaken result.
    a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the output is free");

    // Coordinates are zero for every result that reports no crossing.
    a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_CROSS) |-> (m_axis_tdata == '0))
        else $error("coordinates not zero on a non-crossing result");

    // Only the three defined status codes leave the block.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_CROSS || m_axis_tuser == ST_PARALLEL
                           || m_axis_tuser == ST_OUTSIDE))
        else $error("undefined status code on the output");
`endif

endmodule
